/* hw/rtl/lac_pkg.sv */
// Shared types, codes and helpers for the LRU associative cache.
// No dependencies; lac_entry_mem, lac_scan and the top level import this package.
package lac_pkg;

   // Operation codes carried in the request word
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   // Control from the sequencer to the compare/min unit
   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctl_type;

   // Control from the sequencer to the entry memory
   typedef struct packed {
      logic rd_en;
      logic wr_kv;
      logic wr_stamp;
   } mem_ctl_type;

   // Saturating 32-bit increment
   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

/* hw/rtl/lac_req_if.sv */
// Request channel of the LRU associative cache: valid/ready plus payload.
// No dependencies.
interface lac_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [31:0] key;
   logic signed [31:0] value_in;

   modport source (output valid, output op, output key, output value_in, input ready);
   modport sink   (input valid, input op, input key, input value_in, output ready);
endinterface

/* hw/rtl/lac_rsp_if.sv */
// Response channel of the LRU associative cache: valid/ready plus payload.
// No dependencies.
interface lac_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] value_out;
   logic [31:0]        hit_count;
   logic [31:0]        miss_count;

   modport source (output valid, output hit, output value_out, output hit_count,
                   output miss_count, input ready);
   modport sink   (input valid, input hit, input value_out, input hit_count,
                   input miss_count, output ready);
endinterface

/* hw/rtl/lac_entry_mem.sv */
// Entry store of the cache: key, value and stamp per slot, one write port,
// one registered read port. Depends on lac_pkg.
module lac_entry_mem
   import lac_pkg::*;
#(
   parameter int ENTRIES = 16,
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic               clock,
   input  mem_ctl_type        ctl,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic signed [31:0] wr_key,
   input  logic signed [31:0] wr_value,
   input  logic [31:0]        wr_stamp,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic signed [31:0] rd_key,
   output logic signed [31:0] rd_value,
   output logic [31:0]        rd_stamp
);

   logic signed [31:0] key_mem   [ENTRIES];
   logic signed [31:0] value_mem [ENTRIES];
   logic [31:0]        stamp_mem [ENTRIES];

   logic signed [31:0] rd_key_ff;
   logic signed [31:0] rd_value_ff;
   logic [31:0]        rd_stamp_ff;

   // Write key/value on insert, stamp on any touch
   always_ff @(posedge clock) begin
      if (ctl.wr_kv) begin
         key_mem[wr_addr]   <= wr_key;
         value_mem[wr_addr] <= wr_value;
      end
      if (ctl.wr_stamp) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_key_ff   <= key_mem[rd_addr];
         rd_value_ff <= value_mem[rd_addr];
         rd_stamp_ff <= stamp_mem[rd_addr];
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule

/* hw/rtl/lac_scan.sv */
// Shared compare unit: one entry per sample, tracks the first valid key
// match and the oldest stamp (lowest index on ties). Depends on lac_pkg.
module lac_scan
   import lac_pkg::*;
#(
   parameter int ENTRIES = 16,
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  scan_ctl_type       ctl,
   input  logic [IDX_W-1:0]   idx,
   input  logic               entry_valid,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] entry_key,
   input  logic signed [31:0] entry_value,
   input  logic [31:0]        entry_stamp,
   output logic               found,
   output logic [IDX_W-1:0]   match_idx,
   output logic signed [31:0] match_value,
   output logic [IDX_W-1:0]   lru_idx
);

   logic               found_ff, found_in;
   logic               seen_ff, seen_in;
   logic [IDX_W-1:0]   match_idx_ff, match_idx_in;
   logic signed [31:0] match_value_ff, match_value_in;
   logic [31:0]        best_stamp_ff, best_stamp_in;
   logic [IDX_W-1:0]   lru_idx_ff, lru_idx_in;
   logic               is_match;
   logic               is_older;

   assign is_match = entry_valid && (entry_key == req_key);
   assign is_older = !seen_ff || (entry_stamp < best_stamp_ff);

   // Compare the sampled entry against the running results
   always_comb begin
      found_in       = found_ff;
      seen_in        = seen_ff;
      match_idx_in   = match_idx_ff;
      match_value_in = match_value_ff;
      best_stamp_in  = best_stamp_ff;
      lru_idx_in     = lru_idx_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
         seen_in  = 1'b0;
      end else if (ctl.sample) begin
         seen_in = 1'b1;
         if (!found_ff && is_match) begin
            found_in       = 1'b1;
            match_idx_in   = idx;
            match_value_in = entry_value;
         end
         if (is_older) begin
            best_stamp_in = entry_stamp;
            lru_idx_in    = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         seen_ff  <= 1'b0;
      end else begin
         found_ff <= found_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff   <= match_idx_in;
      match_value_ff <= match_value_in;
      best_stamp_ff  <= best_stamp_in;
      lru_idx_ff     <= lru_idx_in;
   end

   assign found       = found_ff;
   assign match_idx   = match_idx_ff;
   assign match_value = match_value_ff;
   assign lru_idx     = lru_idx_ff;

endmodule

/* hw/rtl/lru_assoc_cache_top.sv */
// Top level of the LRU associative cache; instantiates lac_entry_mem and
// lac_scan. Depends on lac_pkg, lac_req_if and lac_rsp_if.

// Fully associative key/value cache with stamp-based LRU replacement. One
// request word (lookup or insert) is handled at a time: after acceptance the
// sequencer reads the active slots one per cycle through the single read port
// of the entry memory into a shared compare unit, then, in the write state,
// does write-back and loads the response register. The request side is ready
// again while an earlier response word still waits to be taken; write-back
// stalls only if that response has not left by then. Writing the active-entry
// register is legal only while the block is idle; a value of zero acts as one
// and a value above ENTRIES acts as ENTRIES. No clearing pass is needed after
// reset.
module lru_assoc_cache_top
   import lac_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,
   lac_req_if.sink     req_port,
   lac_rsp_if.source   rsp_port
);

   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   active_n_ff, active_n_in;
   logic [CNT_W-1:0]   csr_n;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [CNT_W-1:0]   filled_ff, filled_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]        time_ff, time_in;
   logic [31:0]        hits_ff, hits_in;
   logic [31:0]        misses_ff, misses_in;

   logic               op_ff;
   logic signed [31:0] key_ff;
   logic signed [31:0] value_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_hit_in;
   logic signed [31:0] rsp_value_in;

   logic               accept;
   logic               out_free;
   logic               do_write;
   logic               scan_done;
   logic               is_fill;
   logic [IDX_W-1:0]   wr_slot;
   scan_ctl_type       scan_ctl;
   mem_ctl_type        mem_ctl;

   logic signed [31:0] rd_key;
   logic signed [31:0] rd_value;
   logic [31:0]        rd_stamp;
   logic               found;
   logic [IDX_W-1:0]   match_idx;
   logic signed [31:0] match_value;
   logic [IDX_W-1:0]   lru_idx;

   assign accept    = req_port.valid && req_port.ready;
   assign out_free  = !rsp_valid_ff || rsp_port.ready;
   assign scan_done = (idx_ff == active_n_ff);

   // Clamp the written active-entry count into 1..ENTRIES
   always_comb begin
      if (csr_wr_data == '0) begin
         csr_n = CNT_W'(1);
      end else if (32'(csr_wr_data) > 32'(ENTRIES)) begin
         csr_n = CNT_W'(ENTRIES);
      end else begin
         csr_n = CNT_W'(csr_wr_data);
      end
   end

   assign active_n_in = csr_wr_en ? csr_n : active_n_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_port.ready   = 1'b0;
      scan_ctl.clear   = 1'b0;
      scan_ctl.sample  = rd_vld_ff;
      mem_ctl.rd_en    = 1'b0;
      do_write         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_port.ready = 1'b1;
            scan_ctl.clear = req_port.valid;
         end
         ST_SCAN: begin
            mem_ctl.rd_en = !scan_done;
         end
         ST_WRITE: begin
            do_write = out_free;
         end
         default: begin
            req_port.ready = 1'b0;
         end
      endcase
      mem_ctl.wr_kv    = do_write && (op_ff == OP_INSERT);
      mem_ctl.wr_stamp = do_write && ((op_ff == OP_INSERT) || found);
   end

   // Advance the scan index while reads are issued
   always_comb begin
      if (state_ff == ST_IDLE) begin
         idx_in = '0;
      end else if (mem_ctl.rd_en) begin
         idx_in = idx_ff + CNT_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   // Pick the slot to write: match, then next free, then oldest
   assign is_fill = (op_ff == OP_INSERT) && !found && (filled_ff < active_n_ff);

   always_comb begin
      if (found) begin
         wr_slot = match_idx;
      end else if (is_fill) begin
         wr_slot = filled_ff[IDX_W-1:0];
      end else begin
         wr_slot = lru_idx;
      end
   end

   // Write-back of time, counters, fill count and valid bits
   always_comb begin
      time_in      = time_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      filled_in    = filled_ff;
      valid_in     = valid_ff;
      rsp_hit_in   = 1'b0;
      rsp_value_in = '0;
      if (do_write) begin
         if (mem_ctl.wr_stamp) begin
            time_in = sat_inc(time_ff);
         end
         if (op_ff == OP_LOOKUP) begin
            if (found) begin
               hits_in      = sat_inc(hits_ff);
               rsp_hit_in   = 1'b1;
               rsp_value_in = match_value;
            end else begin
               misses_in = sat_inc(misses_ff);
            end
         end else begin
            valid_in = valid_ff | (ENTRIES'(1) << wr_slot);
            if (is_fill) begin
               filled_in = filled_ff + CNT_W'(1);
            end
         end
      end
   end

   // Hold the response word until taken
   always_comb begin
      if (do_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_n_ff  <= CNT_W'(ENTRIES);
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         filled_ff    <= '0;
         valid_ff     <= '0;
         time_ff      <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_n_ff  <= active_n_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= mem_ctl.rd_en;
         filled_ff    <= filled_in;
         valid_ff     <= valid_in;
         time_ff      <= time_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= idx_ff[IDX_W-1:0];
      if (accept) begin
         op_ff    <= req_port.op;
         key_ff   <= req_port.key;
         value_ff <= req_port.value_in;
      end
      if (do_write) begin
         rsp_hit_ff   <= rsp_hit_in;
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.hit        = rsp_hit_ff;
   assign rsp_port.value_out  = rsp_value_ff;
   assign rsp_port.hit_count  = hits_ff;
   assign rsp_port.miss_count = misses_ff;

   lac_entry_mem #(
      .ENTRIES (ENTRIES)
   ) u_mem (
      .clock    (clock),
      .ctl      (mem_ctl),
      .wr_addr  (wr_slot),
      .wr_key   (key_ff),
      .wr_value (value_ff),
      .wr_stamp (time_in),
      .rd_addr  (idx_ff[IDX_W-1:0]),
      .rd_key   (rd_key),
      .rd_value (rd_value),
      .rd_stamp (rd_stamp)
   );

   lac_scan #(
      .ENTRIES (ENTRIES)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .idx         (rd_idx_ff),
      .entry_valid (valid_ff[rd_idx_ff]),
      .req_key     (key_ff),
      .entry_key   (rd_key),
      .entry_value (rd_value),
      .entry_stamp (rd_stamp),
      .found       (found),
      .match_idx   (match_idx),
      .match_value (match_value),
      .lru_idx     (lru_idx)
   );

   // Fill count never passes the built slot count
   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      32'(filled_ff) <= 32'(ENTRIES))
      else $error("fill count above slot count");

   // An accepted word always starts a scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN) && (idx_ff == '0))
      else $error("accepted word did not start a scan");

   // A response is loaded only with the output register free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      do_write |-> (!rsp_valid_ff || rsp_port.ready))
      else $error("response overwritten before taken");

   // Hit counter never steps back outside reset
   a_hits_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> hits_ff >= $past(hits_ff))
      else $error("hit counter decreased");

endmodule
